FILE: rtl/ssmd_pkg.sv
// Package for the subarray-sum-multiple detector.
// Holds transfer payload types, sizing constants and the control state type.
// No dependencies.
`default_nettype none

package ssmd_pkg;

  localparam int unsigned MAX_MODULUS = 1024;
  localparam int unsigned TAB_AW      = $clog2(MAX_MODULUS);
  localparam int unsigned MOD_W       = 11;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned SUM_W       = 17;
  localparam int unsigned STEP_W      = $clog2(SUM_W);
  // table entry: valid bit on top, first-seen position below
  localparam int unsigned ENTRY_W     = POS_W + 1;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              first_of_array;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_UPD
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/ssmd_ram.sv
// Generic single-port synchronous RAM with registered read.
// Standalone; no package dependency.
`default_nettype none

module ssmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/subarray_sum_multiple_detector.sv
// Subarray-sum-multiple detector: an accepted input goes through the remainder division, the table
// read and the update, which loads the result once the output can take it; then the next input is taken.
// An item flagged first_of_array adds a table clearing pass over all 1024 entries before its own work;
// the table RAM port is busy one entry per cycle during that pass.
// Reset (rst_ni low, async) clears control state and starts the same clearing pass;
// modulus resets to 1. Configuration writes are taken in any cycle.
`default_nettype none

module subarray_sum_multiple_detector (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration
  input  wire logic            cfg_we_i,
  input  wire logic [10:0]     cfg_wdata_i,
  // input channel
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ssmd_pkg::in_t   in_data_i,
  // output channel
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ssmd_pkg::out_t       out_data_o
);

  import ssmd_pkg::*;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [MOD_W-1:0]    modulus_q;
  logic [TAB_AW-1:0]   rr_q, rr_d;          // running prefix remainder
  logic [POS_W-1:0]    pos_q, pos_d;        // position of next element
  logic [POS_W-1:0]    cur_pos_q, cur_pos_d;
  logic                found_q, found_d;
  logic [TAB_AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic                go_div_q, go_div_d;  // item waits behind the clearing pass
  logic [SUM_W-1:0]    dvd_q, dvd_d;        // dividend, shifted out msb first
  logic [MOD_W-1:0]    div_rem_q, div_rem_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  // table RAM
  logic                ram_we, ram_re;
  logic [TAB_AW-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  // ---------------------------------------------------------------------------
  // Effective modulus: zero reads as 1, anything above the table size saturates
  // ---------------------------------------------------------------------------
  logic [MOD_W-1:0] eff_k;
  always_comb begin
    if (modulus_q == '0) begin
      eff_k = MOD_W'(1);
    end else if (modulus_q > MOD_W'(MAX_MODULUS)) begin
      eff_k = MOD_W'(MAX_MODULUS);
    end else begin
      eff_k = modulus_q;
    end
  end

  // one restoring-division step
  logic [MOD_W:0] trial;
  logic [MOD_W:0] trial_sub;
  assign trial     = {div_rem_q, dvd_q[SUM_W-1]};
  assign trial_sub = trial - {1'b0, eff_k};

  // table entry fields as read back
  logic              ent_valid;
  logic [POS_W-1:0]  ent_pos;
  logic [SUM_W-1:0]  ent_pos_plus2;
  assign ent_valid     = ram_rdata[ENTRY_W-1];
  assign ent_pos       = ram_rdata[POS_W-1:0];
  assign ent_pos_plus2 = {1'b0, ent_pos} + SUM_W'(2);

  logic in_xfer, out_xfer, can_load;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;
  assign can_load = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_W'(1);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rr_q        <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      clr_cnt_q   <= '0;
      go_div_q    <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rr_q        <= rr_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      clr_cnt_q   <= clr_cnt_d;
      go_div_q    <= go_div_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    cur_pos_q <= cur_pos_d;
    dvd_q     <= dvd_d;
    div_rem_q <= div_rem_d;
    out_q     <= out_d;
  end

  // ---------------------------------------------------------------------------
  // Next state and datapath
  // The RAM sees one access per cycle and the update of one item is written
  // before the next item can read, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    rr_d        = rr_q;
    pos_d       = pos_q;
    cur_pos_d   = cur_pos_q;
    found_d     = found_q;
    clr_cnt_d   = clr_cnt_q;
    go_div_d    = go_div_q;
    dvd_d       = dvd_q;
    div_rem_d   = div_rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = clr_cnt_q;
    ram_wdata   = '0;
    in_stall_o  = 1'b1;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        // one table entry per cycle
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + TAB_AW'(1);
        if (clr_cnt_q == TAB_AW'(MAX_MODULUS - 1)) begin
          state_d  = go_div_q ? S_DIV : S_IDLE;
          go_div_d = 1'b0;
        end
      end

      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          div_rem_d = '0;
          step_d    = '0;
          if (in_data_i.first_of_array) begin
            // new array: prefix remainder and position restart, table cleared
            dvd_d     = SUM_W'(in_data_i.element);
            cur_pos_d = '0;
            pos_d     = POS_W'(1);
            rr_d      = '0;
            found_d   = 1'b0;
            clr_cnt_d = '0;
            go_div_d  = 1'b1;
            state_d   = S_CLEAR;
          end else begin
            // (rr mod k + e) mod k equals (rr + e) mod k
            dvd_d     = SUM_W'(in_data_i.element) + SUM_W'(rr_q);
            cur_pos_d = pos_q;
            if (pos_q != '1) begin
              pos_d = pos_q + POS_W'(1);
            end
            state_d   = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (trial >= {1'b0, eff_k}) begin
          div_rem_d = trial_sub[MOD_W-1:0];
        end else begin
          div_rem_d = trial[MOD_W-1:0];
        end
        dvd_d  = {dvd_q[SUM_W-2:0], 1'b0};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = S_READ;
        end
      end

      S_READ: begin
        ram_re   = 1'b1;
        ram_addr = div_rem_q[TAB_AW-1:0];
        state_d  = S_UPD;
      end

      S_UPD: begin
        ram_addr = div_rem_q[TAB_AW-1:0];
        if (can_load) begin
          found_d = found_q;
          if (div_rem_q == '0) begin
            // remainder zero is seeded at position minus one
            if (cur_pos_q != '0) begin
              found_d = 1'b1;
            end
          end else if (ent_valid) begin
            if ({1'b0, cur_pos_q} >= ent_pos_plus2) begin
              found_d = 1'b1;
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, cur_pos_q};
          end
          rr_d              = div_rem_q[TAB_AW-1:0];
          out_d.found       = found_d;
          out_d.position    = cur_pos_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // First-seen table: valid bit plus position, 1024 entries
  // ---------------------------------------------------------------------------
  ssmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MODULUS)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

`ifndef ASSERT_OFF
  // partial remainder stays below the modulus throughout the reduction
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_rem_q < eff_k))
    else $error("partial remainder not below modulus");

  // an accepted item blocks the input until its work is done
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // remainder zero is never stored in the table
  a_no_zero_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_CLEAR) |-> (ram_addr != '0 && ram_wdata[ENTRY_W-1]))
    else $error("table update to the seeded remainder");

  // a result is loaded only from the update step
  a_load_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !out_valid_q) |-> (state_q == S_UPD))
    else $error("result loaded outside the update step");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for subarray_sum_multiple_detector: directed and random element streams,
// with a prefix-remainder predictor and scoreboard held in this file.
// Depends on ssmd_pkg for the payload types and sizing constants.

module tb;

  import ssmd_pkg::*;

  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 105;
  // settle time after draining, so the block is back in idle before a register write
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES     = 40;
  // long receiver hold-off, so the single-item pipe fills and stalls its input
  localparam int unsigned LONG_HOLD       = 800;
  // well above the longest quiet stretch, set by the clearing pass or the receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT  = 20000;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Prefix-remainder predictor plus the queue of detections still to arrive.
  class detection_scoreboard;
    logic [MOD_W-1:0]  modulus_q;
    logic [TAB_AW-1:0] prefix_rem;
    logic [POS_W-1:0]  next_pos;
    logic              found_q;
    logic [POS_W-1:0]  first_pos [MAX_MODULUS];
    logic              seen      [MAX_MODULUS];
    out_t              expected_detections [$];
    int unsigned       failures;

    function new();
      modulus_q = 11'd1;
      failures  = 0;
      start_array();
    endfunction

    static function int unsigned effective_k(logic [MOD_W-1:0] m);
      int unsigned k;
      k = m;
      if (k == 0) k = 1;
      if (k > MAX_MODULUS) k = MAX_MODULUS;
      return k;
    endfunction

    function void start_array();
      prefix_rem = '0;
      next_pos   = '0;
      found_q    = 1'b0;
      foreach (seen[i]) seen[i] = 1'b0;
    endfunction

    function void set_modulus(logic [MOD_W-1:0] value);
      modulus_q = value;
    endfunction

    // Works out the detection for one accepted element and queues it.
    function void note_element(in_t item);
      int unsigned k;
      int unsigned rem;
      out_t        det;
      k = effective_k(modulus_q);
      if (item.first_of_array) start_array();
      rem = (prefix_rem % k + item.element) % k;
      if (rem == 0) begin
        // remainder zero counts as seen just before the array
        if (next_pos >= 1) found_q = 1'b1;
      end else if (seen[rem]) begin
        if (next_pos > first_pos[rem] && next_pos - first_pos[rem] > 1) found_q = 1'b1;
      end else begin
        seen[rem]      = 1'b1;
        first_pos[rem] = next_pos;
      end
      det.found    = found_q;
      det.position = next_pos;
      expected_detections.insert(expected_detections.size(), det);
      prefix_rem = TAB_AW'(rem);
      if (next_pos != '1) next_pos = next_pos + 1'b1;
    endfunction

    function void report(string what, out_t want, out_t got);
      failures++;
      if (failures <= 10)
        $display("%s: expected found=%0b position=%0d, got found=%0b position=%0d",
                 what, want.found, want.position, got.found, got.position);
    endfunction

    function void check_detection(out_t got);
      out_t want;
      if (expected_detections.size() == 0) begin
        report("result with no element outstanding", '0, got);
        return;
      end
      want = expected_detections.pop_front();
      if (got.found !== want.found || got.position !== want.position)
        report("detection mismatch", want, got);
    endfunction
  endclass

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           cfg_we_i    = 1'b0;
  logic [10:0]    cfg_wdata_i = '0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  in_t            in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  out_t           out_data_o;

  detection_scoreboard sb;
  idle_mode_e          idle_mode    = IDLE_NONE;
  bit                  hold_request = 1'b0;
  int unsigned         quiet_cycles = 0;

  subarray_sum_multiple_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 77;
    if (idle_mode == IDLE_BOTH)   return $urandom_range(0, 99) < 33;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 77;
    if (idle_mode == IDLE_BOTH)     return $urandom_range(0, 99) < 33;
    return 1'b0;
  endfunction

  // Element mix: plain random values, tiny values, exact multiples of k, values
  // around k, zeros and the top value, so remainders repeat often enough.
  function automatic logic [ELEM_W-1:0] pick_element(int unsigned k);
    case ($urandom_range(0, 9))
      0, 1, 2: return ELEM_W'($urandom);
      3, 4:    return ELEM_W'($urandom_range(0, 3));
      5, 6:    return ELEM_W'(k * $urandom_range(0, 65535 / k));
      7:       return ELEM_W'(k - 1 + $urandom_range(0, 2));
      8:       return '0;
      default: return '1;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge on which the transfer happened.
  // Junk goes on the bus while valid is low.
  task automatic send_element(input logic [ELEM_W-1:0] elem, input logic first);
    in_t item;
    item.element        = elem;
    item.first_of_array = first;
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      in_data_i  <= in_t'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_element(item);
  endtask

  // Sender stops offering until every detection owed has come back.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_detections.size() != 0) @(posedge clk_i);
  endtask

  // Register writes only with the block idle: drain, let it settle, then one pulse.
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_modulus(value);
  endtask

  // Result side: check every transfer, then choose next cycle's stall. A requested
  // hold-off is counted down here so the sender keeps pushing meanwhile.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_detection(out_data_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_stalls();
      end
    end
  end

  // Watchdog: too many cycles without a transfer on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL subarray_sum_multiple_detector");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned k;
    int unsigned left;
    int unsigned n;
    logic        starts;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // modulus straight out of reset is 1; reset acts as an array start
    send_element(16'd0, 1'b0);
    send_element(16'hFFFF, 1'b0);
    send_element(16'd7, 1'b1);
    write_modulus(11'd7);
    send_element(16'd3, 1'b1);   // prefix reaches a multiple at position 1
    send_element(16'd4, 1'b0);
    send_element(16'd5, 1'b1);   // repeat one apart is too short, two apart counts
    send_element(16'd7, 1'b0);
    send_element(16'd14, 1'b0);
    send_element(16'd0, 1'b1);   // zero at position 0 alone does not qualify
    send_element(16'd0, 1'b0);
    write_modulus(11'd0);        // zero acts as 1
    send_element(16'hFFFF, 1'b1);
    send_element(16'd1, 1'b0);
    write_modulus(11'h7FF);      // saturates to the table size
    send_element(16'd1023, 1'b1);
    send_element(16'd1, 1'b0);
    send_element(16'hFFFF, 1'b0);
    write_modulus(11'd1024);
    send_element(16'd1000, 1'b1);
    send_element(16'd50, 1'b0);
    write_modulus(11'd5);        // changed mid-array: old remainder and table kept
    send_element(16'd0, 1'b0);
    send_element(16'd3, 1'b0);

    // --- random phases: idling pattern and modulus change per phase ---
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      idle_mode = idle_mode_e'(phase % 4);
      case (phase)
        0:       write_modulus(11'($urandom_range(2, 16)));
        1:       write_modulus(11'd1024);
        2:       write_modulus(11'd1);
        3:       write_modulus(11'($urandom_range(17, 1024)));
        4:       write_modulus(11'd0);
        5:       write_modulus(11'($urandom_range(1025, 2047)));
        6:       write_modulus(11'h7FF);
        default: write_modulus(11'($urandom_range(2, 64)));
      endcase
      k    = detection_scoreboard::effective_k(sb.modulus_q);
      left = 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (left == 0) begin
          left = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
          // the odd phase carries on the array left over from the last one
          starts = (n > 0) || ($urandom_range(0, 3) != 0);
        end
        if (phase == 1 && n == 40) hold_request = 1'b1;
        if (phase == 6 && n == 50) pause_until_drained();
        send_element(pick_element(k), starts);
        starts = 1'b0;
        left--;
      end
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_detections.size() == 0)
      $display("PASS subarray_sum_multiple_detector");
    else
      $display("FAIL subarray_sum_multiple_detector");
    $finish;
  end

endmodule
